@@ src/cau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Commands, status codes and the per-item control word of the complex unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    // control that travels with an item down the divide chain
    typedef struct packed {
        cmd_t cmd;
        logic div_zero;
        logic sat;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } ctl_t;

endpackage
`default_nettype wire

@@ src/cau_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step for both parts: one quotient bit per cell.
// ----------------------------------------------------------------------------
module cau_div_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  cau_pkg::ctl_t             ctl_i,
    input  logic [2*DATA_WIDTH-1:0]   den_i,
    input  logic [2*DATA_WIDTH-1:0]   rem_re_i,
    input  logic [2*DATA_WIDTH-1:0]   rem_im_i,
    input  logic [DATA_WIDTH-1:0]     sr_re_i,
    input  logic [DATA_WIDTH-1:0]     sr_im_i,
    input  logic [DATA_WIDTH-1:0]     res_re_i,
    input  logic [DATA_WIDTH-1:0]     res_im_i,
    output logic                      valid_o,
    output cau_pkg::ctl_t             ctl_o,
    output logic [2*DATA_WIDTH-1:0]   den_o,
    output logic [2*DATA_WIDTH-1:0]   rem_re_o,
    output logic [2*DATA_WIDTH-1:0]   rem_im_o,
    output logic [DATA_WIDTH-1:0]     sr_re_o,
    output logic [DATA_WIDTH-1:0]     sr_im_o,
    output logic [DATA_WIDTH-1:0]     res_re_o,
    output logic [DATA_WIDTH-1:0]     res_im_o
);
    import cau_pkg::*;

    localparam int W = DATA_WIDTH;

    logic            valid_reg;
    ctl_t            ctl_reg;
    logic [2*W-1:0]  den_reg, rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [W-1:0]    sr_re_reg, sr_im_reg, sr_re_next, sr_im_next;
    logic [W-1:0]    res_re_reg, res_im_reg;
    logic [2*W:0]    t_re, t_im, d_re, d_im;
    logic            ge_re, ge_im;

    always_comb begin
        // bring down the next dividend bit, subtract where it fits
        t_re = {rem_re_i, sr_re_i[W-1]};
        t_im = {rem_im_i, sr_im_i[W-1]};
        d_re = t_re - {1'b0, den_i};
        d_im = t_im - {1'b0, den_i};
        ge_re = (t_re >= {1'b0, den_i});
        ge_im = (t_im >= {1'b0, den_i});
        rem_re_next = ge_re ? d_re[2*W-1:0] : t_re[2*W-1:0];
        rem_im_next = ge_im ? d_im[2*W-1:0] : t_im[2*W-1:0];
        sr_re_next = {sr_re_i[W-2:0], ge_re};
        sr_im_next = {sr_im_i[W-2:0], ge_im};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg    <= ctl_i;
            den_reg    <= den_i;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            sr_re_reg  <= sr_re_next;
            sr_im_reg  <= sr_im_next;
            res_re_reg <= res_re_i;
            res_im_reg <= res_im_i;
        end
    end

    assign valid_o  = valid_reg;
    assign ctl_o    = ctl_reg;
    assign den_o    = den_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign sr_re_o  = sr_re_reg;
    assign sr_im_o  = sr_im_reg;
    assign res_re_o = res_re_reg;
    assign res_im_o = res_im_reg;

endmodule
`default_nettype wire

@@ src/cau_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, sums of products, then saturation and divide setup.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [2:0]                       en,
    input  logic                             in_valid,
    input  cau_pkg::cmd_t                    cmd_i,
    input  logic signed [DATA_WIDTH-1:0]     ar_i,
    input  logic signed [DATA_WIDTH-1:0]     ai_i,
    input  logic signed [DATA_WIDTH-1:0]     br_i,
    input  logic signed [DATA_WIDTH-1:0]     bi_i,
    output logic [2:0]                       valid_o,
    output cau_pkg::ctl_t                    ctl_o,
    output logic [2*DATA_WIDTH-1:0]          den_o,
    output logic [2*DATA_WIDTH-1:0]          rem_re_o,
    output logic [2*DATA_WIDTH-1:0]          rem_im_o,
    output logic [DATA_WIDTH-1:0]            sr_re_o,
    output logic [DATA_WIDTH-1:0]            sr_im_o,
    output logic [DATA_WIDTH-1:0]            res_re_o,
    output logic [DATA_WIDTH-1:0]            res_im_o
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W + 1;
    localparam int NW = 2 * W + F;
    localparam int CW = (W + F > 2 * W) ? W + F : 2 * W;

    localparam logic signed [SW-1:0] SMAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    logic [2:0] valid_reg;

    // stage A
    cmd_t                  a_cmd_reg;
    logic signed [2*W-1:0] a_rr_reg, a_ii_reg, a_ri_reg, a_ir_reg, a_br2_reg, a_bi2_reg;
    logic signed [W:0]     a_as_reg, a_as_im_reg, a_as_next, a_as_im_next;

    // stage B
    cmd_t                  b_cmd_reg;
    logic signed [SW-1:0]  b_val_re_reg, b_val_im_reg, b_n_re_reg, b_n_im_reg;
    logic signed [SW-1:0]  b_val_re_next, b_val_im_next, mul_re, mul_im;
    logic [2*W-1:0]        b_den_reg, b_den_next;

    // stage C
    ctl_t                  c_ctl_reg, c_ctl_next;
    logic [2*W-1:0]        c_den_reg, c_rem_re_reg, c_rem_im_reg, c_rem_re_next, c_rem_im_next;
    logic [W-1:0]          c_sr_re_reg, c_sr_im_reg, c_res_re_reg, c_res_im_reg;
    logic [W-1:0]          c_sr_re_next, c_sr_im_next, c_res_re_next, c_res_im_next;
    logic [SW-1:0]         neg_re, neg_im;
    logic [NW-1:0]         nm_re, nm_im;
    logic [CW-1:0]         hi_re, hi_im, den_ext;
    logic                  sat_re, sat_im;

    always_comb begin
        if (cmd_i == CMD_SUB) begin
            a_as_next    = (W + 1)'(ar_i) - (W + 1)'(br_i);
            a_as_im_next = (W + 1)'(ai_i) - (W + 1)'(bi_i);
        end else begin
            a_as_next    = (W + 1)'(ar_i) + (W + 1)'(br_i);
            a_as_im_next = (W + 1)'(ai_i) + (W + 1)'(bi_i);
        end
    end

    always_comb begin
        mul_re = (SW'(a_rr_reg) - SW'(a_ii_reg)) >>> F;
        mul_im = (SW'(a_ri_reg) + SW'(a_ir_reg)) >>> F;
        if (a_cmd_reg == CMD_MUL) begin
            b_val_re_next = mul_re;
            b_val_im_next = mul_im;
        end else begin
            b_val_re_next = SW'(a_as_reg);
            b_val_im_next = SW'(a_as_im_reg);
        end
        b_den_next = $unsigned(a_br2_reg) + $unsigned(a_bi2_reg);
    end

    always_comb begin
        // clamp the non-divide result
        sat_re = 1'b0;
        sat_im = 1'b0;
        c_res_re_next = b_val_re_reg[W-1:0];
        c_res_im_next = b_val_im_reg[W-1:0];
        if (b_val_re_reg > SMAX) begin
            sat_re = 1'b1;
            c_res_re_next = SMAX[W-1:0];
        end else if (b_val_re_reg < SMIN) begin
            sat_re = 1'b1;
            c_res_re_next = SMIN[W-1:0];
        end
        if (b_val_im_reg > SMAX) begin
            sat_im = 1'b1;
            c_res_im_next = SMAX[W-1:0];
        end else if (b_val_im_reg < SMIN) begin
            sat_im = 1'b1;
            c_res_im_next = SMIN[W-1:0];
        end

        // divide on magnitudes; quotient below 2^W or flagged as overflow
        neg_re = -b_n_re_reg;
        neg_im = -b_n_im_reg;
        nm_re = NW'(b_n_re_reg[SW-1] ? neg_re[2*W-1:0] : b_n_re_reg[2*W-1:0]) << F;
        nm_im = NW'(b_n_im_reg[SW-1] ? neg_im[2*W-1:0] : b_n_im_reg[2*W-1:0]) << F;
        hi_re = CW'(nm_re[NW-1:W]);
        hi_im = CW'(nm_im[NW-1:W]);
        den_ext = CW'(b_den_reg);

        c_ctl_next.cmd      = b_cmd_reg;
        c_ctl_next.div_zero = (b_cmd_reg == CMD_DIV) && (b_den_reg == '0);
        c_ctl_next.sat      = (b_cmd_reg != CMD_DIV) && (sat_re || sat_im);
        c_ctl_next.neg_re   = b_n_re_reg[SW-1];
        c_ctl_next.neg_im   = b_n_im_reg[SW-1];
        c_ctl_next.ovf_re   = (hi_re >= den_ext);
        c_ctl_next.ovf_im   = (hi_im >= den_ext);
        c_rem_re_next = c_ctl_next.ovf_re ? '0 : hi_re[2*W-1:0];
        c_rem_im_next = c_ctl_next.ovf_im ? '0 : hi_im[2*W-1:0];
        c_sr_re_next  = nm_re[W-1:0];
        c_sr_im_next  = nm_im[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_cmd_reg   <= cmd_i;
            a_rr_reg    <= ar_i * br_i;
            a_ii_reg    <= ai_i * bi_i;
            a_ri_reg    <= ar_i * bi_i;
            a_ir_reg    <= ai_i * br_i;
            a_br2_reg   <= br_i * br_i;
            a_bi2_reg   <= bi_i * bi_i;
            a_as_reg    <= a_as_next;
            a_as_im_reg <= a_as_im_next;
        end
        if (en[1]) begin
            b_cmd_reg    <= a_cmd_reg;
            b_val_re_reg <= b_val_re_next;
            b_val_im_reg <= b_val_im_next;
            b_n_re_reg   <= SW'(a_rr_reg) + SW'(a_ii_reg);
            b_n_im_reg   <= SW'(a_ir_reg) - SW'(a_ri_reg);
            b_den_reg    <= b_den_next;
        end
        if (en[2]) begin
            c_ctl_reg    <= c_ctl_next;
            c_den_reg    <= b_den_reg;
            c_rem_re_reg <= c_rem_re_next;
            c_rem_im_reg <= c_rem_im_next;
            c_sr_re_reg  <= c_sr_re_next;
            c_sr_im_reg  <= c_sr_im_next;
            c_res_re_reg <= c_res_re_next;
            c_res_im_reg <= c_res_im_next;
        end
    end

    assign valid_o  = valid_reg;
    assign ctl_o    = c_ctl_reg;
    assign den_o    = c_den_reg;
    assign rem_re_o = c_rem_re_reg;
    assign rem_im_o = c_rem_im_reg;
    assign sr_re_o  = c_sr_re_reg;
    assign sr_im_o  = c_sr_im_reg;
    assign res_re_o = c_res_re_reg;
    assign res_im_o = c_res_im_reg;

endmodule
`default_nettype wire

@@ src/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// One item enters per cycle unless the output stalls; each item passes through
// three front stages (products, sums, saturation and divide setup), a chain of
// DATA_WIDTH division cells that each settle one quotient bit for both parts,
// and an output register. Stages fill empty slots while the output is stalled.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Streaming complex ALU with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_real, a_imag, b_real, b_imag
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
    // command
    input  logic [1:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // res_real, res_imag
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    // status
    output logic [1:0]                                m_tuser
);
    import cau_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int NST   = W + 4;
    localparam int OUT_W = ((2 * W + 7) / 8) * 8;

    logic [NST-1:0] en, valid;

    ctl_t           ctl   [W+1];
    logic [2*W-1:0] den   [W+1];
    logic [2*W-1:0] rem_re[W+1];
    logic [2*W-1:0] rem_im[W+1];
    logic [W-1:0]   sr_re [W+1];
    logic [W-1:0]   sr_im [W+1];
    logic [W-1:0]   res_re[W+1];
    logic [W-1:0]   res_im[W+1];

    logic           m_valid_reg;
    logic [W-1:0]   m_re_reg, m_im_reg, m_re_next, m_im_next;
    status_t        m_status_reg, m_status_next;
    logic           sat_re, sat_im;
    logic [W-1:0]   q_re, q_im;
    ctl_t           c_last;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NST-1] = !valid[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !valid[i] || en[i+1];
        end
    end

    assign valid[NST-1] = m_valid_reg;
    assign s_tready     = en[0];

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en[2:0]),
        .in_valid (s_tvalid),
        .cmd_i    (cmd_t'(s_tuser)),
        .ar_i     (s_tdata[W-1:0]),
        .ai_i     (s_tdata[2*W-1:W]),
        .br_i     (s_tdata[3*W-1:2*W]),
        .bi_i     (s_tdata[4*W-1:3*W]),
        .valid_o  (valid[2:0]),
        .ctl_o    (ctl[0]),
        .den_o    (den[0]),
        .rem_re_o (rem_re[0]),
        .rem_im_o (rem_im[0]),
        .sr_re_o  (sr_re[0]),
        .sr_im_o  (sr_im[0]),
        .res_re_o (res_re[0]),
        .res_im_o (res_im[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_cell
        cau_div_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en[k+3]),
            .in_valid (valid[k+2]),
            .ctl_i    (ctl[k]),
            .den_i    (den[k]),
            .rem_re_i (rem_re[k]),
            .rem_im_i (rem_im[k]),
            .sr_re_i  (sr_re[k]),
            .sr_im_i  (sr_im[k]),
            .res_re_i (res_re[k]),
            .res_im_i (res_im[k]),
            .valid_o  (valid[k+3]),
            .ctl_o    (ctl[k+1]),
            .den_o    (den[k+1]),
            .rem_re_o (rem_re[k+1]),
            .rem_im_o (rem_im[k+1]),
            .sr_re_o  (sr_re[k+1]),
            .sr_im_o  (sr_im[k+1]),
            .res_re_o (res_re[k+1]),
            .res_im_o (res_im[k+1])
        );
    end

    // sign, saturation and status of the finished item
    always_comb begin
        c_last = ctl[W];
        q_re   = sr_re[W];
        q_im   = sr_im[W];
        if (c_last.neg_re) begin
            sat_re    = c_last.ovf_re || (q_re[W-1] && (|q_re[W-2:0]));
            m_re_next = sat_re ? {1'b1, {(W - 1){1'b0}}} : -q_re;
        end else begin
            sat_re    = c_last.ovf_re || q_re[W-1];
            m_re_next = sat_re ? {1'b0, {(W - 1){1'b1}}} : q_re;
        end
        if (c_last.neg_im) begin
            sat_im    = c_last.ovf_im || (q_im[W-1] && (|q_im[W-2:0]));
            m_im_next = sat_im ? {1'b1, {(W - 1){1'b0}}} : -q_im;
        end else begin
            sat_im    = c_last.ovf_im || q_im[W-1];
            m_im_next = sat_im ? {1'b0, {(W - 1){1'b1}}} : q_im;
        end
        m_status_next = (sat_re || sat_im) ? ST_SAT : ST_OK;
        if (c_last.cmd != CMD_DIV) begin
            m_re_next     = res_re[W];
            m_im_next     = res_im[W];
            m_status_next = c_last.sat ? ST_SAT : ST_OK;
        end else if (c_last.div_zero) begin
            m_re_next     = '0;
            m_im_next     = '0;
            m_status_next = ST_DIV_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en[NST-1]) begin
            m_valid_reg <= valid[NST-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            m_re_reg     <= m_re_next;
            m_im_reg     <= m_im_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_im_reg, m_re_reg});
    assign m_tuser  = m_status_reg;

endmodule
`default_nettype wire

@@ src/cau_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  logic [1:0]                            s_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
    input  logic [1:0]                            m_tuser
);
    import cau_pkg::*;

    localparam int FB = FRAC_BITS;

    // no result item in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item right after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_DIV_ZERO || m_tuser == ST_SAT))
        else $error("unused status code");

    a_div_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_DIV_ZERO) |-> (m_tdata == '0))
        else $error("divide by zero with non-zero result");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result item changed");

    // a stalled input with a free output register must be taken
    a_input_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && FB >= 0) |-> s_tready)
        else $error("input stalled with empty output");

    a_input_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
        else $error("offered input item has unknown bits");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_cau_checker (.*);
`default_nettype wire
